@@ sv/engine_speed_fault_monitor_unit_defines.svh @@
// Assertion macros shared by the engine speed fault monitor RTL.
`ifndef ENGINE_SPEED_FAULT_MONITOR_UNIT_DEFINES_SVH
`define ENGINE_SPEED_FAULT_MONITOR_UNIT_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define ESFM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("esfm assertion failed");

// Same, with a caller-supplied message.
`define ESFM_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ sv/esfm_pkg.sv @@
// Package: widths, codes and reset values of the engine speed fault monitor.
`default_nettype none

package esfm_pkg;

  localparam int unsigned FAULT_DEPTH_DEF = 20;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LAMP_W    = 2;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVAL  = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_RAISE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERSPEED_LIMIT  = 2'd0,
    REG_UNDERSPEED_LIMIT = 2'd1,
    REG_UNDERSPEED_HOLD  = 2'd2
  } cfg_reg_e;

  localparam logic [LIMIT_W-1:0] OVERSPEED_LIMIT_RST  = 16'd2500;
  localparam logic [LIMIT_W-1:0] UNDERSPEED_LIMIT_RST = 16'd500;
  localparam logic [LIMIT_W-1:0] UNDERSPEED_HOLD_RST  = 16'd1000;

  localparam logic [LAMP_W-1:0] LAMP_NONE     = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_SHUTDOWN = 2'd3;

  localparam logic [CODE_W-1:0] CODE_NONE       = 8'd0;
  localparam logic [CODE_W-1:0] CODE_OVERSPEED  = 8'd1;
  localparam logic [CODE_W-1:0] CODE_UNDERSPEED = 8'd2;

endpackage

`default_nettype wire

@@ sv/esfm_ifs.sv @@
// Interfaces: command input, status output and configuration write channels.
`default_nettype none

interface esfm_in_if;
  logic                           valid;
  logic                           ready;
  logic [esfm_pkg::CMD_W-1:0]     cmd;
  logic [esfm_pkg::FREQ_W-1:0]    speed_frequency;
  logic                           engine_running;
  logic [esfm_pkg::TIME_W-1:0]    now_ms;
  logic [esfm_pkg::LAMP_W-1:0]    raise_lamp;
  logic [esfm_pkg::CODE_W-1:0]    raise_code;

  modport source (
    output valid, cmd, speed_frequency, engine_running, now_ms, raise_lamp, raise_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, speed_frequency, engine_running, now_ms, raise_lamp, raise_code,
    output ready
  );
endinterface

interface esfm_out_if;
  logic                              valid;
  logic                              ready;
  logic                              stop_request;
  logic                              overspeed_raised;
  logic                              underspeed_raised;
  logic [esfm_pkg::CNT_OUT_W-1:0]    stored_faults;
  logic [esfm_pkg::LAMP_W-1:0]       head_lamp;
  logic [esfm_pkg::CODE_W-1:0]       head_code;

  modport source (
    output valid, stop_request, overspeed_raised, underspeed_raised,
           stored_faults, head_lamp, head_code,
    input  ready
  );
  modport sink (
    input  valid, stop_request, overspeed_raised, underspeed_raised,
           stored_faults, head_lamp, head_code,
    output ready
  );
endinterface

interface esfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [esfm_pkg::CFG_IDX_W-1:0]  index;
  logic [esfm_pkg::LIMIT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/engine_speed_fault_monitor_unit.sv @@
// Engine speed fault monitor: one input register, one pass of logic, one result register.
//
// Each command item (evaluate, acknowledge, raise) returns exactly one status item. The block
// takes one item per clock while each status is taken on the output. The item is captured in
// the input register; the fault list and underspeed timer are then updated as the status is
// loaded into the result register. The fault list is a shift line of FAULT_DEPTH slots held
// in flops, so an acknowledge shifts the whole list in one update. A status not taken on the
// output stalls the result register, and the input register then holds one more item before
// the input stops. Configuration writes are always taken and apply to items evaluated
// afterwards.
`default_nettype none

module engine_speed_fault_monitor_unit #(
  parameter int unsigned FAULT_DEPTH = esfm_pkg::FAULT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  esfm_in_if.sink    in_i,
  esfm_out_if.source out_o,
  esfm_cfg_if.sink   cfg_i
);
  import esfm_pkg::*;

  `include "engine_speed_fault_monitor_unit_defines.svh"

  localparam int unsigned CNT_W = $clog2(FAULT_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FAULT_DEPTH);

  // Configuration registers
  logic [LIMIT_W-1:0] ovr_lim_q, und_lim_q, hold_q;

  // Input register
  logic               in_vld_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [FREQ_W-1:0]  freq_q;
  logic               run_q;
  logic [TIME_W-1:0]  now_q;
  logic [LAMP_W-1:0]  lamp_in_q;
  logic [CODE_W-1:0]  code_in_q;

  // Fault list and timer state
  logic [LAMP_W-1:0]  lamp_arr_q [FAULT_DEPTH];
  logic [CODE_W-1:0]  code_arr_q [FAULT_DEPTH];
  logic [LAMP_W-1:0]  lamp_arr_d [FAULT_DEPTH];
  logic [CODE_W-1:0]  code_arr_d [FAULT_DEPTH];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic               armed_q, armed_d;

  // Result register
  logic                 out_vld_q;
  logic                 res_stop_q, res_stop_d;
  logic                 res_over_q, res_over_d;
  logic                 res_under_q, res_under_d;
  logic [CNT_OUT_W-1:0] res_cnt_q;
  logic [LAMP_W-1:0]    res_lamp_q;
  logic [CODE_W-1:0]    res_code_q;

  logic               advance;
  logic               in_xfer;
  logic               over_hit;
  logic               under_cond;
  logic               under_trip;
  logic [TIME_W-1:0]  elapsed;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign over_hit   = run_q && (freq_q > ovr_lim_q);
  assign under_cond = run_q && (freq_q < und_lim_q);
  assign elapsed    = now_q - start_q;
  assign under_trip = under_cond && armed_q
                      && (elapsed > {{(TIME_W - LIMIT_W){1'b0}}, hold_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovr_lim_q <= OVERSPEED_LIMIT_RST;
      und_lim_q <= UNDERSPEED_LIMIT_RST;
      hold_q    <= UNDERSPEED_HOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_OVERSPEED_LIMIT:  ovr_lim_q <= cfg_i.data;
        REG_UNDERSPEED_LIMIT: und_lim_q <= cfg_i.data;
        REG_UNDERSPEED_HOLD:  hold_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0] cnt_v;
    lamp_arr_d  = lamp_arr_q;
    code_arr_d  = code_arr_q;
    start_d     = start_q;
    armed_d     = armed_q;
    res_stop_d  = 1'b0;
    res_over_d  = 1'b0;
    res_under_d = 1'b0;
    cnt_v       = cnt_q;
    case (cmd_e'(cmd_q))
      CMD_EVAL: begin
        if (over_hit) begin
          res_stop_d = 1'b1;
          res_over_d = 1'b1;
          if (cnt_v < DEPTH_C) begin
            for (int j = 0; j < FAULT_DEPTH; j++) begin
              if (CNT_W'(j) == cnt_v) begin
                lamp_arr_d[j] = LAMP_SHUTDOWN;
                code_arr_d[j] = CODE_OVERSPEED;
              end
            end
            cnt_v = cnt_v + 1'b1;
          end
        end
        if (under_cond) begin
          if (!armed_q) begin
            start_d = now_q;
            armed_d = 1'b1;
          end else if (under_trip) begin
            res_stop_d  = 1'b1;
            res_under_d = 1'b1;
            start_d     = '0;
            if (cnt_v < DEPTH_C) begin
              for (int j = 0; j < FAULT_DEPTH; j++) begin
                if (CNT_W'(j) == cnt_v) begin
                  lamp_arr_d[j] = LAMP_SHUTDOWN;
                  code_arr_d[j] = CODE_UNDERSPEED;
                end
              end
              cnt_v = cnt_v + 1'b1;
            end
          end
        end else begin
          armed_d = 1'b0;
        end
      end
      CMD_ACK: begin
        // shift down behind the head; the old last slot keeps stale contents unless the list empties
        if (cnt_q != '0) begin
          for (int j = 0; j < FAULT_DEPTH - 1; j++) begin
            if (CNT_W'(j + 1) < cnt_q) begin
              lamp_arr_d[j] = lamp_arr_q[j + 1];
              code_arr_d[j] = code_arr_q[j + 1];
            end
          end
          cnt_v = cnt_q - 1'b1;
        end
        if (cnt_v == '0) begin
          lamp_arr_d[0] = LAMP_NONE;
          code_arr_d[0] = CODE_NONE;
        end
      end
      CMD_RAISE: begin
        if (cnt_q < DEPTH_C) begin
          for (int j = 0; j < FAULT_DEPTH; j++) begin
            if (CNT_W'(j) == cnt_q) begin
              lamp_arr_d[j] = lamp_in_q;
              code_arr_d[j] = code_in_q;
            end
          end
          // an empty fault fills the slot but does not count
          if ((lamp_in_q != LAMP_NONE) || (code_in_q != CODE_NONE)) begin
            cnt_v = cnt_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
    cnt_d = cnt_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
      start_q   <= '0;
      armed_q   <= 1'b0;
      for (int j = 0; j < FAULT_DEPTH; j++) begin
        lamp_arr_q[j] <= '0;
        code_arr_q[j] <= '0;
      end
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        cnt_q      <= cnt_d;
        start_q    <= start_d;
        armed_q    <= armed_d;
        lamp_arr_q <= lamp_arr_d;
        code_arr_q <= code_arr_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: input capture on transfer, result capture on advance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q     <= in_i.cmd;
      freq_q    <= in_i.speed_frequency;
      run_q     <= in_i.engine_running;
      now_q     <= in_i.now_ms;
      lamp_in_q <= in_i.raise_lamp;
      code_in_q <= in_i.raise_code;
    end
    if (advance) begin
      res_stop_q  <= res_stop_d;
      res_over_q  <= res_over_d;
      res_under_q <= res_under_d;
      res_cnt_q   <= CNT_OUT_W'(cnt_d);
      res_lamp_q  <= lamp_arr_d[0];
      res_code_q  <= code_arr_d[0];
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.stop_request      = res_stop_q;
  assign out_o.overspeed_raised  = res_over_q;
  assign out_o.underspeed_raised = res_under_q;
  assign out_o.stored_faults     = res_cnt_q;
  assign out_o.head_lamp         = res_lamp_q;
  assign out_o.head_code         = res_code_q;

  `ESFM_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= DEPTH_C)
  `ESFM_ASSERT(a_over_implies_stop, clk_i, rst_ni, (out_vld_q && res_over_q) |-> res_stop_q)
  `ESFM_ASSERT_MSG(a_trip_clears_start, clk_i, rst_ni,
    (advance && (cmd_q == CMD_EVAL) && under_trip) |=> (start_q == '0),
    "underspeed trip did not clear start time")
  `ESFM_ASSERT_MSG(a_idle_holds_count, clk_i, rst_ni, !advance |=> $stable(cnt_q),
    "fault count changed without an item")

endmodule

`default_nettype wire
